/* src/eul_pkg.sv */
// ---------------------------------------------------------------------------
// eul_pkg
// shared types, constants and the cordic arctangent table
// ---------------------------------------------------------------------------
package eul_pkg;

  localparam int IN_W     = 16;   // matrix element width, q1.14
  localparam int OP_W     = 17;   // cordic operand width, holds a negated element
  localparam int CW       = 36;   // cordic x/y datapath width
  localparam int ZW       = 25;   // angle accumulator width, q.20 radians
  localparam int RW       = 18;   // rounded angle width before saturation
  localparam int SQ_STEPS = 15;   // root digits for a 29-bit radicand
  localparam int SQ_VW    = 29;   // radicand width
  localparam int SQ_RW    = 30;   // root working width
  localparam int ROOT_W   = 15;   // root result width
  localparam int TAB_LEN  = 24;

  localparam logic signed [ZW-1:0] PI_Q20      = 25'sd3294199;
  localparam logic signed [RW-1:0] PI_Q13      = 18'sd25736;
  localparam logic signed [RW-1:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [IN_W-1:0] ONE_Q14   = 16'sd16384;

  // operands and flags carried alongside the root
  typedef struct packed {
    logic signed [IN_W-1:0] r02;
    logic signed [OP_W-1:0] xa_y;
    logic signed [OP_W-1:0] xa_x;
    logic signed [OP_W-1:0] za_y;
    logic signed [OP_W-1:0] za_x;
    logic                   sing_pos;
    logic                   sing_neg;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q20(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 25'sd823550;
      1:  r = 25'sd486170;
      2:  r = 25'sd256879;
      3:  r = 25'sd130396;
      4:  r = 25'sd65451;
      5:  r = 25'sd32757;
      6:  r = 25'sd16383;
      7:  r = 25'sd8192;
      8:  r = 25'sd4096;
      9:  r = 25'sd2048;
      10: r = 25'sd1024;
      11: r = 25'sd512;
      12: r = 25'sd256;
      13: r = 25'sd128;
      14: r = 25'sd64;
      15: r = 25'sd32;
      16: r = 25'sd16;
      17: r = 25'sd8;
      18: r = 25'sd4;
      19: r = 25'sd2;
      20: r = 25'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/eul_isqrt.sv */
// ---------------------------------------------------------------------------
// eul_isqrt
// pipelined floor square root of 2^28 - r02^2, one digit per stage
// ---------------------------------------------------------------------------
module eul_isqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [31:0]                 sq,
  input  eul_pkg::side_t                     side_in,
  output logic                               out_valid,
  output logic [eul_pkg::ROOT_W-1:0]         root,
  output eul_pkg::side_t                     side_out
);

  localparam int N = eul_pkg::SQ_STEPS;

  logic                          vld  [0:N];
  logic [eul_pkg::SQ_VW-1:0]     rad  [0:N];
  logic [eul_pkg::SQ_RW-1:0]     res  [0:N];
  eul_pkg::side_t                sd   [0:N];

  // input stage: radicand, wraps like the unsigned original when singular
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rad[0] <= eul_pkg::SQ_VW'(33'sd268435456 - 33'(sq));
    res[0] <= '0;
    sd[0]  <= side_in;
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [eul_pkg::SQ_RW-1:0] BIT = eul_pkg::SQ_RW'(1) << (28 - 2 * k);
    logic [eul_pkg::SQ_RW-1:0] trial;
    assign trial = res[k] + BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      if (eul_pkg::SQ_RW'(rad[k]) >= trial) begin
        rad[k+1] <= eul_pkg::SQ_VW'(eul_pkg::SQ_RW'(rad[k]) - trial);
        res[k+1] <= (res[k] >> 1) + BIT;
      end else begin
        rad[k+1] <= rad[k];
        res[k+1] <= res[k] >> 1;
      end
      sd[k+1] <= sd[k];
    end
  end

  assign out_valid = vld[N];
  assign root      = res[N][eul_pkg::ROOT_W-1:0];
  assign side_out  = sd[N];

endmodule

/* src/eul_cordic.sv */
// ---------------------------------------------------------------------------
// eul_cordic
// pipelined vectoring cordic, atan2(y, x) in q.20 radians
// ---------------------------------------------------------------------------
module eul_cordic #(
  parameter int STAGES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic signed [eul_pkg::OP_W-1:0]  x_in,
  input  logic signed [eul_pkg::OP_W-1:0]  y_in,
  output logic                             out_valid,
  output logic signed [eul_pkg::ZW-1:0]    z_out
);

  localparam int CW = eul_pkg::CW;

  logic                        vld  [0:STAGES];
  logic                        zero [0:STAGES];
  logic signed [CW-1:0]        xr   [0:STAGES];
  logic signed [CW-1:0]        yr   [0:STAGES];
  logic signed [eul_pkg::ZW-1:0] zr [0:STAGES];

  logic signed [eul_pkg::OP_W-1:0] xs, ys;

  // fold the left half plane onto the right, starting from +-pi
  assign xs = x_in[eul_pkg::OP_W-1] ? -x_in : x_in;
  assign ys = x_in[eul_pkg::OP_W-1] ? -y_in : y_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    zero[0] <= (x_in == '0) && (y_in == '0);
    xr[0]   <= CW'(xs) <<< 16;
    yr[0]   <= CW'(ys) <<< 16;
    if (x_in[eul_pkg::OP_W-1]) begin
      zr[0] <= y_in[eul_pkg::OP_W-1] ? -eul_pkg::PI_Q20 : eul_pkg::PI_Q20;
    end else begin
      zr[0] <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      zero[i+1] <= zero[i];
      if (yr[i] > 0) begin
        xr[i+1] <= xr[i] + (yr[i] >>> i);
        yr[i+1] <= yr[i] - (xr[i] >>> i);
        zr[i+1] <= zr[i] + eul_pkg::atan_q20(i);
      end else begin
        xr[i+1] <= xr[i] - (yr[i] >>> i);
        yr[i+1] <= yr[i] + (xr[i] >>> i);
        zr[i+1] <= zr[i] - eul_pkg::atan_q20(i);
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign z_out     = zero[STAGES] ? '0 : zr[STAGES];

endmodule

/* src/rotation_matrix_to_euler_xyz.sv */
// ---------------------------------------------------------------------------
// rotation_matrix_to_euler_xyz
// rotation matrix (q1.14) to xyz euler angles (q3.13 radians)
// ---------------------------------------------------------------------------
// usage:
//   a word (seven matrix elements) is taken on a rising edge with start high
//   and busy low. busy is never raised: the pipeline takes one word a cycle.
//   each result appears on angle_x/angle_y/angle_z for one cycle, marked by
//   done; the receiver cannot hold results off and none is needed.
// pipeline, in order from accept to done:
//   input register, r02 squaring, 16 root stages (load plus 15 digits),
//   cordic fold stage plus CORDIC_STAGES iterations, output rounding.
// throughput:
//   one word per cycle, set by the fully unrolled root and cordic pipelines.
// reset:
//   rst clears all valid bits; words in flight are dropped, data regs keep
//   whatever they hold.
// singular cases (|r02| >= 1.0) fix angle_y at +-pi/2, zero angle_z and take
// angle_x from atan2(r10, r11), negated for the negative pole.
// ---------------------------------------------------------------------------
module rotation_matrix_to_euler_xyz #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] r00,
  input  logic signed [15:0] r01,
  input  logic signed [15:0] r02,
  input  logic signed [15:0] r10,
  input  logic signed [15:0] r11,
  input  logic signed [15:0] r12,
  input  logic signed [15:0] r22,
  output logic               done,
  output logic signed [15:0] angle_x,
  output logic signed [14:0] angle_y,
  output logic signed [15:0] angle_z
);

  localparam int OP_W = eul_pkg::OP_W;
  localparam int ZW   = eul_pkg::ZW;
  localparam int RW   = eul_pkg::RW;

  // never stalls
  assign busy = 1'b0;

  // stage 0: capture the word
  logic                   v0;
  logic signed [15:0]     q00, q01, q02, q10, q11, q12, q22;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    q00 <= r00;
    q01 <= r01;
    q02 <= r02;
    q10 <= r10;
    q11 <= r11;
    q12 <= r12;
    q22 <= r22;
  end

  // stage 1: square r02, pick the x- and z-angle operands, flag the poles
  logic               v1;
  logic signed [31:0] sq;
  eul_pkg::side_t     side1;
  logic               pos0, neg0;

  assign pos0 = q02 >= eul_pkg::ONE_Q14;
  assign neg0 = q02 <= -eul_pkg::ONE_Q14;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    sq             <= q02 * q02;
    side1.r02      <= q02;
    side1.xa_y     <= (pos0 || neg0) ? OP_W'(q10) : -OP_W'(q12);
    side1.xa_x     <= (pos0 || neg0) ? OP_W'(q11) : OP_W'(q22);
    side1.za_y     <= -OP_W'(q01);
    side1.za_x     <= OP_W'(q00);
    side1.sing_pos <= pos0;
    side1.sing_neg <= neg0;
  end

  // root of 1 - r02^2, the cosine of angle_y
  logic                        v2;
  logic [eul_pkg::ROOT_W-1:0]  root;
  eul_pkg::side_t              side2;

  eul_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .sq        (sq),
    .side_in   (side1),
    .out_valid (v2),
    .root      (root),
    .side_out  (side2)
  );

  // three parallel cordics
  logic                 vy, vx_unused_free;
  logic signed [ZW-1:0] zy, zx, zz;
  logic                 vx, vz;

  eul_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .x_in      (OP_W'(signed'({1'b0, root}))),
    .y_in      (OP_W'(side2.r02)),
    .out_valid (vy),
    .z_out     (zy)
  );

  eul_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .x_in      (side2.xa_x),
    .y_in      (side2.xa_y),
    .out_valid (vx),
    .z_out     (zx)
  );

  eul_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .x_in      (side2.za_x),
    .y_in      (side2.za_y),
    .out_valid (vz),
    .z_out     (zz)
  );

  assign vx_unused_free = vx && vz;

  // pole flags ride along the cordic latency
  logic pos_d [0:CORDIC_STAGES];
  logic neg_d [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    pos_d[0] <= side2.sing_pos;
    neg_d[0] <= side2.sing_neg;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      pos_d[i+1] <= pos_d[i];
      neg_d[i+1] <= neg_d[i];
    end
  end

  // round half up to q3.13, then saturate
  function automatic logic signed [RW-1:0] to_q13(input logic signed [ZW-1:0] z,
                                                  input logic signed [RW-1:0] lim);
    logic signed [ZW-1:0] t;
    logic signed [RW-1:0] r;
    t = (z + ZW'(64)) >>> 7;
    r = t[RW-1:0];
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic signed [RW-1:0] ax_r, ay_r, az_r;
  logic                 sing;

  assign sing = pos_d[CORDIC_STAGES] || neg_d[CORDIC_STAGES];
  assign ax_r = to_q13(zx, eul_pkg::PI_Q13);
  assign ay_r = to_q13(zy, eul_pkg::HALF_PI_Q13);
  assign az_r = to_q13(zz, eul_pkg::PI_Q13);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vy && vx_unused_free;
    end
    angle_x <= neg_d[CORDIC_STAGES] ? -ax_r[15:0] : ax_r[15:0];
    if (pos_d[CORDIC_STAGES]) begin
      angle_y <= eul_pkg::HALF_PI_Q13[14:0];
    end else if (neg_d[CORDIC_STAGES]) begin
      angle_y <= -eul_pkg::HALF_PI_Q13[14:0];
    end else begin
      angle_y <= ay_r[14:0];
    end
    angle_z <= sing ? '0 : az_r[15:0];
  end

`ifndef SYNTHESIS
  localparam int LAT = 20 + CORDIC_STAGES;

  // every result traces back to an accepted word
  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without accepted word");

  a_y_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (angle_y <= 15'sd12868) && (angle_y >= -15'sd12868))
    else $error("angle_y out of range");

  a_x_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (angle_x <= 16'sd25736) && (angle_x >= -16'sd25736))
    else $error("angle_x out of range");
`endif

endmodule

/* verif/rotation_matrix_to_euler_xyz_test.sv */
// ---------------------------------------------------------------------------
// rotation_matrix_to_euler_xyz_test
// checks the matrix to euler angle pipeline against a fixed-point predictor
// directed corners and poles, then random matrices under several idle phases
// ---------------------------------------------------------------------------
module rotation_matrix_to_euler_xyz_test;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected set of angles
  typedef struct {
    logic signed [15:0] ax;
    logic signed [14:0] ay;
    logic signed [15:0] az;
  } angles_t;

  // reports one mismatch and counts it
  int errors = 0;
  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // ---- fixed-point predictor ----
  localparam int STAGES = 16;

  function automatic longint atan_entry(input int i);
    longint tab[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1,
                        0, 0, 0};
    return tab[i];
  endfunction

  // arctangent in q.20 radians by vectoring iterations
  function automatic longint vector_angle(input longint y, input longint x);
    longint z, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 3294199 : -3294199;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atan_entry(i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atan_entry(i);
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint round_q13(input longint z, input longint lim);
    longint r;
    r = (z + 64) >>> 7;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint floor_root(input longint v);
    longint r;
    r = 0;
    for (int b = 15; b >= 0; b--)
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r += (64'sd1 << b);
    return r;
  endfunction

  function automatic angles_t predict_angles(input logic signed [15:0] m[7]);
    angles_t a;
    longint e00, e01, e02, e10, e11, e12, e22, c, tx;
    e00 = m[0]; e01 = m[1]; e02 = m[2]; e10 = m[3];
    e11 = m[4]; e12 = m[5]; e22 = m[6];
    if (e02 >= 16384) begin
      a.ay = 15'sd12868;
      a.ax = 16'(round_q13(vector_angle(e10, e11), 25736));
      a.az = '0;
    end else if (e02 <= -16384) begin
      a.ay = -15'sd12868;
      tx = round_q13(vector_angle(e10, e11), 25736);
      a.ax = 16'(-tx);
      a.az = '0;
    end else begin
      c = floor_root((64'sd1 << 28) - e02 * e02);
      a.ay = 15'(round_q13(vector_angle(e02, c), 12868));
      a.ax = 16'(round_q13(vector_angle(-e12, e22), 25736));
      a.az = 16'(round_q13(vector_angle(-e01, e00), 25736));
    end
    return a;
  endfunction

  // ---- scoreboard ----
  class angle_board;
    angles_t pending[$];
    function void note_matrix(input logic signed [15:0] m[7]);
      pending.push_back(predict_angles(m));
    endfunction
    task check_angles(input logic signed [15:0] ax, input logic signed [14:0] ay,
                      input logic signed [15:0] az);
      angles_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (ax !== e.ax) report_mismatch($sformatf("angle_x %0d want %0d", ax, e.ax));
      if (ay !== e.ay) report_mismatch($sformatf("angle_y %0d want %0d", ay, e.ay));
      if (az !== e.az) report_mismatch($sformatf("angle_z %0d want %0d", az, e.az));
    endtask
  endclass

  // ---- block ----
  logic clk = 0, rst = 1, start = 0, busy, done;
  logic signed [15:0] r00 = 0, r01 = 0, r02 = 0, r10 = 0, r11 = 0, r12 = 0, r22 = 0;
  logic signed [15:0] angle_x, angle_z;
  logic signed [14:0] angle_y;

  rotation_matrix_to_euler_xyz dut (.*);

  angle_board board = new();
  int idle_pct = 0;

  initial forever #5 clk = ~clk;

  // results are taken at the edge that closes their cycle
  always @(posedge clk)
    if (!rst && done) board.check_angles(angle_x, angle_y, angle_z);

  // drives one word, holding start until the block takes it
  task automatic send_matrix(input logic signed [15:0] m[7]);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    {r00, r01, r02, r10, r11, r12, r22} <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6]};
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_matrix(m);
  endtask

  // one element in q1.14: a raw random word, +-1.0, a small value near zero or a value in [-1.0, 1.0]
  function automatic logic signed [15:0] pick_elem();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return 16'sd16384;
    if (k == 2) return -16'sd16384;
    if (k == 3) return 16'($signed($urandom_range(16)) - 8);
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  initial begin
    logic signed [15:0] m[7];
    logic signed [15:0] corners[8] = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1,
                                       16'sd16384, -16'sd16384, 16'sd16383};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // identity, poles, zero operands, negative x with zero y, extremes
    m = '{16384, 0, 0, 0, 16384, 0, 16384};       send_matrix(m);
    m = '{0, 0, 16384, 5000, 9000, 0, 0};         send_matrix(m);
    m = '{0, 0, -16384, 5000, 9000, 0, 0};        send_matrix(m);
    m = '{0, 0, 16'sh7fff, 0, 0, 0, 0};           send_matrix(m);
    m = '{0, 0, 16'sh8000, 0, -16384, 0, 0};      send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0};                   send_matrix(m);
    m = '{-16384, 0, 0, 0, 0, 0, -16384};         send_matrix(m);
    m = '{16'sh8000, 16'sh8000, 16383, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000};
    send_matrix(m);
    m = '{16'sh7fff, 16'sh7fff, -16383, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
    send_matrix(m);
    m = '{16'shffff, 16'shffff, 1, -1, -1, -1, -1}; send_matrix(m);
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 7; j++) m[j] = corners[(i + j) % 8];
      send_matrix(m);
    end

    // random phases: none, sender idle heavy, mixed, then none again
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 86 : (ph == 2) ? 24 : 0;
      for (int n = 0; n < 350; n++) begin
        for (int j = 0; j < 7; j++) m[j] = pick_elem();
        if ($urandom_range(3) == 0) m[2] = 16'($urandom);
        send_matrix(m);
      end
    end
    start <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("** rotation_matrix_to_euler_xyz: PASSED **");
    else
      $display("** rotation_matrix_to_euler_xyz: FAILED **");
    $finish;
  end

  // run limit far beyond the slowest correct run
  initial begin
    #2ms;
    $display("** rotation_matrix_to_euler_xyz: FAILED **");
    $finish;
  end
endmodule
